// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL files. Every macro samples on the rising
// edge of i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/upe_pkg.sv
// ----------------------------------------------------------------------------
// upe_pkg
// Shared types of the URI percent encoder: the command that the front end
// hands to the back end through the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

package upe_pkg;

    typedef enum logic [1:0] {
        CMD_PASS,
        CMD_ERROR,
        CMD_UTF8
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind       kind;
        logic            fin;
        logic [15:0]     pass_char;
        logic [1:0]      last_byte;
        logic [3:0][7:0] bytes;
    } t_cmd;

endpackage

`default_nettype wire

// File: hdl/upe_front.sv
// ----------------------------------------------------------------------------
// upe_front
// Front end: accepts code units, tracks surrogate pairing and the discard
// state, classifies each unit and issues one command per unit that has output.
// ----------------------------------------------------------------------------
`default_nettype none

module upe_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [15:0]   i_code_unit,
    input  wire logic          i_is_final,
    input  wire logic          i_cfg_valid,
    input  wire logic          i_cfg_data,
    input  wire logic          i_fifo_full,
    output logic               o_cmd_valid,
    output upe_pkg::t_cmd      o_cmd
);
    import upe_pkg::*;

    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    logic       r_keep_reserved;
    logic [9:0] r_held_high;
    logic [9:0] n_held_high;
    logic       r_high_pending;
    logic       n_high_pending;
    logic       r_discarding;
    logic       n_discarding;

    logic       w_accept;
    logic       w_unreserved;
    logic       w_reserved;
    logic       w_is_low;
    logic       w_is_high;
    logic [20:0] w_pair_cp;

    function automatic t_cmd utf8_cmd(input logic [20:0] cp, input logic fin);
        t_cmd cmd;
        cmd = '0;
        cmd.kind = CMD_UTF8;
        cmd.fin  = fin;
        if (cp < 21'h80) begin
            cmd.last_byte = 2'd0;
            cmd.bytes[0]  = cp[7:0];
        end else if (cp < 21'h800) begin
            cmd.last_byte = 2'd1;
            cmd.bytes[0]  = {3'b110, cp[10:6]};
            cmd.bytes[1]  = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            cmd.last_byte = 2'd2;
            cmd.bytes[0]  = {4'b1110, cp[15:12]};
            cmd.bytes[1]  = {2'b10, cp[11:6]};
            cmd.bytes[2]  = {2'b10, cp[5:0]};
        end else begin
            cmd.last_byte = 2'd3;
            cmd.bytes[0]  = {5'b11110, cp[20:18]};
            cmd.bytes[1]  = {2'b10, cp[17:12]};
            cmd.bytes[2]  = {2'b10, cp[11:6]};
            cmd.bytes[3]  = {2'b10, cp[5:0]};
        end
        return cmd;
    endfunction

    assign w_accept  = i_push && !i_fifo_full;
    assign w_is_low  = (i_code_unit[15:10] == SURR_LOW_TAG);
    assign w_is_high = (i_code_unit[15:10] == SURR_HIGH_TAG);
    assign w_pair_cp = {1'b0, r_held_high, i_code_unit[9:0]} + SUPP_BASE;

    assign w_unreserved = i_code_unit inside {[16'h0041:16'h005A], [16'h0061:16'h007A],
                                              [16'h0030:16'h0039], 16'h002D, 16'h005F,
                                              16'h002E, 16'h0021, 16'h007E, 16'h002A,
                                              16'h0027, 16'h0028, 16'h0029};
    assign w_reserved   = i_code_unit inside {16'h003B, 16'h002F, 16'h003F, 16'h003A,
                                              16'h0040, 16'h0026, 16'h003D, 16'h002B,
                                              16'h0024, 16'h002C, 16'h0023};

    always_comb begin
        t_cmd err_cmd;
        t_cmd pass_cmd;
        err_cmd        = '0;
        err_cmd.kind   = CMD_ERROR;
        err_cmd.fin    = i_is_final;
        pass_cmd       = '0;
        pass_cmd.kind  = CMD_PASS;
        pass_cmd.fin   = i_is_final;
        pass_cmd.pass_char = i_code_unit;

        o_cmd_valid    = 1'b0;
        o_cmd          = pass_cmd;
        n_held_high    = r_held_high;
        n_high_pending = r_high_pending;
        n_discarding   = r_discarding;

        if (w_accept) begin
            if (r_discarding) begin
                if (i_is_final) begin
                    n_discarding = 1'b0;
                end
            end else if (r_high_pending) begin
                o_cmd_valid    = 1'b1;
                n_high_pending = 1'b0;
                n_held_high    = '0;
                if (!w_is_low) begin
                    o_cmd        = err_cmd;
                    n_discarding = !i_is_final;
                end else begin
                    o_cmd = utf8_cmd(w_pair_cp, i_is_final);
                end
            end else if (w_unreserved || (r_keep_reserved && w_reserved)) begin
                o_cmd_valid = 1'b1;
            end else if (w_is_low || (w_is_high && i_is_final)) begin
                o_cmd_valid  = 1'b1;
                o_cmd        = err_cmd;
                n_held_high  = '0;
                n_discarding = !i_is_final;
            end else if (w_is_high) begin
                n_held_high    = i_code_unit[9:0];
                n_high_pending = 1'b1;
            end else begin
                o_cmd_valid = 1'b1;
                o_cmd       = utf8_cmd({5'd0, i_code_unit}, i_is_final);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_reserved <= 1'b0;
            r_held_high     <= '0;
            r_high_pending  <= 1'b0;
            r_discarding    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_keep_reserved <= i_cfg_data;
            end
            r_held_high    <= n_held_high;
            r_high_pending <= n_high_pending;
            r_discarding   <= n_discarding;
        end
    end

endmodule

`default_nettype wire

// File: hdl/upe_cmd_fifo.sv
// ----------------------------------------------------------------------------
// upe_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module upe_cmd_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire upe_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output upe_pkg::t_cmd      o_head,
    output logic               o_empty
);
    import upe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, !(i_push && o_full), "command pushed into a full queue")
    `ASSERT_ALWAYS(a_no_underflow, !(i_pop && o_empty), "command popped from an empty queue")

endmodule

`default_nettype wire

// File: hdl/upe_back.sv
// ----------------------------------------------------------------------------
// upe_back
// Back end: steps the head command one result per cycle into the output
// register when free or popped (passed char, error marker, percent triplets).
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module upe_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire upe_pkg::t_cmd i_head,
    input  wire logic          i_head_empty,
    output logic               o_head_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [15:0]        o_out_char,
    output logic               o_run_last,
    output logic               o_string_end,
    output logic               o_encode_error
);
    import upe_pkg::*;

    localparam logic [15:0] CHAR_PERCENT = 16'h0025;

    logic        r_out_valid;
    logic [15:0] r_out_char;
    logic        r_run_last;
    logic        r_string_end;
    logic        r_encode_error;
    logic [1:0]  r_byte;
    logic [1:0]  r_pos;

    logic        w_load;
    logic [15:0] w_char;
    logic        w_last;
    logic        w_err;
    logic [7:0]  w_byte;

    function automatic logic [15:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (16'h0030 + {12'd0, nib}) : (16'h0037 + {12'd0, nib});
    endfunction

    assign w_load     = !i_head_empty && (!r_out_valid || i_pop);
    assign o_head_pop = w_load && w_last;
    assign w_byte     = i_head.bytes[r_byte];

    always_comb begin
        w_char = '0;
        w_last = 1'b1;
        w_err  = 1'b0;
        case (i_head.kind)
            CMD_PASS: begin
                w_char = i_head.pass_char;
            end
            CMD_ERROR: begin
                w_err = 1'b1;
            end
            CMD_UTF8: begin
                w_last = (r_byte == i_head.last_byte) && (r_pos == 2'd2);
                case (r_pos)
                    2'd0:    w_char = CHAR_PERCENT;
                    2'd1:    w_char = hex_char(w_byte[7:4]);
                    2'd2:    w_char = hex_char(w_byte[3:0]);
                    default: w_char = '0;
                endcase
            end
            default: begin
                w_err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_char     <= w_char;
            r_run_last     <= w_last;
            r_string_end   <= w_last && (i_head.fin || w_err);
            r_encode_error <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_byte      <= '0;
            r_pos       <= '0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                if (w_last) begin
                    r_byte <= '0;
                    r_pos  <= '0;
                end else if (r_pos == 2'd2) begin
                    r_byte <= r_byte + 2'd1;
                    r_pos  <= '0;
                end else begin
                    r_pos <= r_pos + 2'd1;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_out_char     = r_out_char;
    assign o_run_last     = r_run_last;
    assign o_string_end   = r_string_end;
    assign o_encode_error = r_encode_error;

    `ASSERT_ALWAYS(a_pos_range, r_pos != 2'd3, "triplet position out of range")
    `ASSERT_ALWAYS(a_byte_bound, i_head_empty || (r_byte <= i_head.last_byte), "byte index past command")
    `ASSERT_NEXT(a_err_closes, w_load && (i_head.kind == CMD_ERROR), o_run_last && o_string_end && (o_out_char == 16'h0000), "error result malformed")

endmodule

`default_nettype wire

// File: hdl/uri_percent_encoder.sv
// Throughput: one result per cycle out of the back-end sequencer while its output register
// is free or popped; a unit yields 1, 3, 6 or 9 results, a surrogate pair 12, and the front
// end takes a unit every cycle while the command queue has room. Units that only hold a
// surrogate or are dropped yield no result.
// Reset: synchronous, active low; clears surrogate, discard and queue state, and sets
// keep_reserved to 0. No clearing pass; the block is ready right after reset.
// ----------------------------------------------------------------------------
// uri_percent_encoder
// Percent-encodes a stream of UTF-16 code units as URI text, with upper-case hex
// escapes of the UTF-8 bytes and flagged errors for malformed surrogates.
// ----------------------------------------------------------------------------
`default_nettype none

module uri_percent_encoder #(
    parameter int CMD_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_is_final,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      o_out_char,
    output logic             o_run_last,
    output logic             o_string_end,
    output logic             o_encode_error
);
    import upe_pkg::*;

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_fifo_full;
    t_cmd w_head;
    logic w_head_empty;
    logic w_head_pop;

    assign o_cfg_ready = 1'b1;
    assign full        = w_fifo_full;

    upe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_code_unit (i_code_unit),
        .i_is_final  (i_is_final),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_fifo_full (w_fifo_full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    upe_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_valid),
        .i_cmd   (w_cmd),
        .o_full  (w_fifo_full),
        .i_pop   (w_head_pop),
        .o_head  (w_head),
        .o_empty (w_head_empty)
    );

    upe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_head_empty   (w_head_empty),
        .o_head_pop     (w_head_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_char     (o_out_char),
        .o_run_last     (o_run_last),
        .o_string_end   (o_string_end),
        .o_encode_error (o_encode_error)
    );

endmodule

`default_nettype wire
